[hdl/cursor_overlay_pixel_stream_defines.svh]
// Assertion helpers. Both sample on clock and are off while reset is high.
`ifndef CURSOR_OVERLAY_PIXEL_STREAM_DEFINES_SVH
`define CURSOR_OVERLAY_PIXEL_STREAM_DEFINES_SVH

// Consequent checked in the same cycle.
`define COV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the next cycle.
`define COV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/cov_pkg.sv]
`default_nettype none

package cov_pkg;

   localparam int CURSOR_SIZE  = 16;
   localparam int COORD_BITS   = 12;
   localparam int SIDE_BITS    = $clog2(CURSOR_SIZE);
   localparam int SPRITE_DEPTH = CURSOR_SIZE * CURSOR_SIZE;
   localparam int ADDR_BITS    = $clog2(SPRITE_DEPTH);
   localparam int PIXEL_BITS   = 16;
   localparam int LINE_BITS    = 13;
   localparam int OFFSET_BITS  = 24;
   localparam int INDEX_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;

   localparam logic OP_PASS = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_CURSOR_X    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CURSOR_Y    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLIP_LEFT   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLIP_TOP    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLIP_RIGHT  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLIP_BOTTOM = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_LINE_LENGTH = 3'd6;

   localparam logic [COORD_BITS-1:0] CURSOR_X_RESET    = 12'd100;
   localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET    = 12'd100;
   localparam logic [COORD_BITS-1:0] CLIP_LEFT_RESET   = 12'd0;
   localparam logic [COORD_BITS-1:0] CLIP_TOP_RESET    = 12'd0;
   localparam logic [COORD_BITS-1:0] CLIP_RIGHT_RESET  = 12'd4095;
   localparam logic [COORD_BITS-1:0] CLIP_BOTTOM_RESET = 12'd4095;
   localparam logic [LINE_BITS-1:0]  LINE_LENGTH_RESET = 13'd1024;

   typedef struct packed {
      logic                  operation;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [PIXEL_BITS-1:0] pixel_value;
      logic [INDEX_BITS-1:0] sprite_index;
   } req_word_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]  out_pixel;
      logic [OFFSET_BITS-1:0] frame_offset;
      logic                   write_enable;
   } rsp_word_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [PIXEL_BITS-1:0] data;
   } sprite_wr_type;

endpackage

`default_nettype wire

[hdl/cov_sprite_ram.sv]
`default_nettype none

module cov_sprite_ram (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cov_pkg::sprite_wr_type         wr,
   input  wire logic                           rd_en,
   input  wire logic [cov_pkg::ADDR_BITS-1:0]  rd_addr,
   output logic      [cov_pkg::PIXEL_BITS-1:0] rd_data
);

   logic [cov_pkg::PIXEL_BITS-1:0]   mem [cov_pkg::SPRITE_DEPTH];
   logic [cov_pkg::SPRITE_DEPTH-1:0] valid_ff;
   logic [cov_pkg::PIXEL_BITS-1:0]   rd_data_ff;
   logic                             rd_valid_ff;

   // entries never loaded read as transparent
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[hdl/cursor_overlay_pixel_stream.sv]
// A word accepted goes through the stage 1 registers and then the output register to rsp_valid.
// Throughput: one word per cycle while rsp_ready is high; one sprite RAM read or write per word.
// Stage 1 registers hold the sprite read, clip compare and the line_length product.
// Reset (synchronous) restores the configuration registers to their defaults, clears the
// valid flags and the sprite valid bits at once, so the sprite reads as transparent with no clearing pass.
`default_nettype none
`include "cursor_overlay_pixel_stream_defines.svh"

module cursor_overlay_pixel_stream (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire cov_pkg::req_word_type            req_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output cov_pkg::rsp_word_type                 rsp_word,
   input  wire logic                             csr_we,
   input  wire logic [cov_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [cov_pkg::LINE_BITS-1:0]    csr_wdata
);

   localparam int CB = cov_pkg::COORD_BITS;
   localparam int PB = cov_pkg::COORD_BITS + cov_pkg::LINE_BITS;

   // configuration
   logic [CB-1:0]                 cursor_x_ff, cursor_y_ff;
   logic [CB-1:0]                 clip_left_ff, clip_top_ff;
   logic [CB-1:0]                 clip_right_ff, clip_bottom_ff;
   logic [cov_pkg::LINE_BITS-1:0] line_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff    <= cov_pkg::CURSOR_X_RESET;
         cursor_y_ff    <= cov_pkg::CURSOR_Y_RESET;
         clip_left_ff   <= cov_pkg::CLIP_LEFT_RESET;
         clip_top_ff    <= cov_pkg::CLIP_TOP_RESET;
         clip_right_ff  <= cov_pkg::CLIP_RIGHT_RESET;
         clip_bottom_ff <= cov_pkg::CLIP_BOTTOM_RESET;
         line_length_ff <= cov_pkg::LINE_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cov_pkg::REG_CURSOR_X:    cursor_x_ff    <= csr_wdata[CB-1:0];
            cov_pkg::REG_CURSOR_Y:    cursor_y_ff    <= csr_wdata[CB-1:0];
            cov_pkg::REG_CLIP_LEFT:   clip_left_ff   <= csr_wdata[CB-1:0];
            cov_pkg::REG_CLIP_TOP:    clip_top_ff    <= csr_wdata[CB-1:0];
            cov_pkg::REG_CLIP_RIGHT:  clip_right_ff  <= csr_wdata[CB-1:0];
            cov_pkg::REG_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[CB-1:0];
            cov_pkg::REG_LINE_LENGTH: line_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, s1_adv;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // stage 0: address, box test, clip test, multiply
   logic          is_load, in_box, clip_hit;
   logic [CB-1:0] dx, dy;
   logic [PB-1:0] product;
   cov_pkg::sprite_wr_type          sprite_wr;
   logic [cov_pkg::ADDR_BITS-1:0]   rd_addr;
   logic [cov_pkg::PIXEL_BITS-1:0]  sprite_px;

   assign is_load  = req_word.operation == cov_pkg::OP_LOAD;
   assign dx       = req_word.pixel_x - cursor_x_ff;
   assign dy       = req_word.pixel_y - cursor_y_ff;
   assign in_box   = (req_word.pixel_x >= cursor_x_ff) && (req_word.pixel_y >= cursor_y_ff)
                  && (dx < CB'(cov_pkg::CURSOR_SIZE)) && (dy < CB'(cov_pkg::CURSOR_SIZE));
   assign rd_addr  = {dy[cov_pkg::SIDE_BITS-1:0], dx[cov_pkg::SIDE_BITS-1:0]};
   assign clip_hit = (req_word.pixel_x >= clip_left_ff) && (req_word.pixel_x <= clip_right_ff)
                  && (req_word.pixel_y >= clip_top_ff) && (req_word.pixel_y <= clip_bottom_ff);
   assign product  = PB'(req_word.pixel_y) * PB'(line_length_ff);

   assign sprite_wr.en   = accept && is_load
                        && ({1'b0, req_word.sprite_index}
                            < (cov_pkg::INDEX_BITS + 1)'(cov_pkg::SPRITE_DEPTH));
   assign sprite_wr.addr = cov_pkg::ADDR_BITS'(req_word.sprite_index);
   assign sprite_wr.data = req_word.pixel_value;

   cov_sprite_ram u_sprite (
      .clock   (clock),
      .reset   (reset),
      .wr      (sprite_wr),
      .rd_en   (accept && !is_load),
      .rd_addr (rd_addr),
      .rd_data (sprite_px)
   );

   // stage 1 registers
   logic                               s1_pass_ff, s1_hit_ff, s1_we_ff;
   logic [cov_pkg::PIXEL_BITS-1:0]     s1_pixel_ff;
   logic [cov_pkg::OFFSET_BITS-1:0]    s1_prod_ff;
   logic [CB-1:0]                      s1_px_ff;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pass_ff  <= !is_load;
         s1_hit_ff   <= in_box;
         s1_we_ff    <= clip_hit;
         s1_pixel_ff <= req_word.pixel_value;
         s1_prod_ff  <= product[cov_pkg::OFFSET_BITS-1:0];
         s1_px_ff    <= req_word.pixel_x;
      end
   end

   // stage 2: overlay and output register
   cov_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   always_comb begin
      rsp_word_in = '0;
      if (s1_pass_ff) begin
         rsp_word_in.out_pixel    = (s1_hit_ff && sprite_px != '0) ? sprite_px : s1_pixel_ff;
         rsp_word_in.frame_offset = s1_prod_ff + cov_pkg::OFFSET_BITS'(s1_px_ff);
         rsp_word_in.write_enable = s1_we_ff;
      end
   end

   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `COV_ASSERT_NEXT(a_s1_to_out, s1_adv, rsp_valid, "stage 1 word lost on its way out")
   `COV_ASSERT_NOW(a_full_stall, rsp_valid && !rsp_ready && s1_valid_ff, !req_ready, "took a word into a full pipe")
   `COV_ASSERT_NEXT(a_load_zero, s1_adv && !s1_pass_ff, rsp_word == '0, "load word with nonzero result")

endmodule

`default_nettype wire

[tb/sv/cursor_overlay_pixel_stream_test.sv]
module cursor_overlay_pixel_stream_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cov_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_WORDS   = 50;
   localparam int RANDOM_PHASES = 8;
   localparam int SHOWN_FAULTS  = 10;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_word_type            req_word  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_word_type            rsp_word;
   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [LINE_BITS-1:0]    csr_wdata = '0;

   req_word_type pending_words[$];
   rsp_word_type due_pixels[$];
   int words_queued = 0;
   int words_taken  = 0;
   int fail_count   = 0;
   int cycle_count  = 0;
   int send_gap     = 0;
   int stall_left   = 0;
   bit idling       = 1'b0;
   bit req_fire     = 1'b0;

   // shadow of the block's registers and sprite store
   logic [COORD_BITS-1:0] cur_x, cur_y, clip_l, clip_t, clip_r, clip_b;
   logic [LINE_BITS-1:0]  scan_len;
   logic [PIXEL_BITS-1:0] sprite_mem [SPRITE_DEPTH];

   cursor_overlay_pixel_stream dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_word_type overlay_pixel(req_word_type w);
      rsp_word_type r;
      int dx, dy;
      r = '0;
      if (w.operation == OP_LOAD) begin
         sprite_mem[w.sprite_index] = w.pixel_value;
      end else begin
         dx = int'(w.pixel_x) - int'(cur_x);
         dy = int'(w.pixel_y) - int'(cur_y);
         r.out_pixel = w.pixel_value;
         if (dx >= 0 && dx < CURSOR_SIZE && dy >= 0 && dy < CURSOR_SIZE &&
             sprite_mem[ADDR_BITS'(dy * CURSOR_SIZE + dx)] != '0)
            r.out_pixel = sprite_mem[ADDR_BITS'(dy * CURSOR_SIZE + dx)];
         r.frame_offset = OFFSET_BITS'(w.pixel_y) * OFFSET_BITS'(scan_len)
                        + OFFSET_BITS'(w.pixel_x);
         r.write_enable = w.pixel_x >= clip_l && w.pixel_x <= clip_r &&
                          w.pixel_y >= clip_t && w.pixel_y <= clip_b;
      end
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return {COORD_BITS{1'b1}} - COORD_BITS'($urandom_range(0, 15));
         default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      endcase
   endfunction

   task automatic report_fault(string msg);
      if (fail_count < SHOWN_FAULTS)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [LINE_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_CURSOR_X:    cur_x    = val[COORD_BITS-1:0];
         REG_CURSOR_Y:    cur_y    = val[COORD_BITS-1:0];
         REG_CLIP_LEFT:   clip_l   = val[COORD_BITS-1:0];
         REG_CLIP_TOP:    clip_t   = val[COORD_BITS-1:0];
         REG_CLIP_RIGHT:  clip_r   = val[COORD_BITS-1:0];
         REG_CLIP_BOTTOM: clip_b   = val[COORD_BITS-1:0];
         REG_LINE_LENGTH: scan_len = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [COORD_BITS-1:0] cx, cy, cl, ct, cr, cb,
                             input logic [LINE_BITS-1:0] ll);
      write_reg(REG_CURSOR_X, LINE_BITS'(cx));
      write_reg(REG_CURSOR_Y, LINE_BITS'(cy));
      write_reg(REG_CLIP_LEFT, LINE_BITS'(cl));
      write_reg(REG_CLIP_TOP, LINE_BITS'(ct));
      write_reg(REG_CLIP_RIGHT, LINE_BITS'(cr));
      write_reg(REG_CLIP_BOTTOM, LINE_BITS'(cb));
      write_reg(REG_LINE_LENGTH, ll);
   endtask

   task automatic queue_item(input logic op, input logic [COORD_BITS-1:0] x, y,
                             input logic [PIXEL_BITS-1:0] v,
                             input logic [INDEX_BITS-1:0] si);
      req_word_type w;
      w.operation    = op;
      w.pixel_x      = x;
      w.pixel_y      = y;
      w.pixel_value  = v;
      w.sprite_index = si;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_drained();
      while (words_taken != words_queued || due_pixels.size() != 0)
         @(negedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (idling && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_word  <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      req_fire = !reset && req_valid && req_ready;
      if (!reset) begin
         cycle_count++;
         if (rsp_valid && rsp_ready) begin
            if (due_pixels.size() == 0) begin
               report_fault($sformatf("unexpected word pixel %h offset %h we %b",
                                      rsp_word.out_pixel, rsp_word.frame_offset,
                                      rsp_word.write_enable));
            end else begin
               want = due_pixels.pop_front();
               if (rsp_word !== want)
                  report_fault($sformatf(
                     "got pixel %h offset %h we %b, expected pixel %h offset %h we %b",
                     rsp_word.out_pixel, rsp_word.frame_offset, rsp_word.write_enable,
                     want.out_pixel, want.frame_offset, want.write_enable));
            end
         end
         if (req_fire) begin
            due_pixels.push_back(overlay_pixel(req_word));
            words_taken++;
         end
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [COORD_BITS-1:0] cx, cy, cl, ct, cr, cb, x, y, t;
      logic [LINE_BITS-1:0]  ll;
      logic [PIXEL_BITS-1:0] v;
      logic [INDEX_BITS-1:0] si;

      cur_x    = CURSOR_X_RESET;
      cur_y    = CURSOR_Y_RESET;
      clip_l   = CLIP_LEFT_RESET;
      clip_t   = CLIP_TOP_RESET;
      clip_r   = CLIP_RIGHT_RESET;
      clip_b   = CLIP_BOTTOM_RESET;
      scan_len = LINE_LENGTH_RESET;
      foreach (sprite_mem[i]) sprite_mem[i] = '0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings: overlay hits, transparency, misses at the box edge
      idling = 1'b1;
      queue_item(OP_LOAD, 12'd0, 12'd0, 16'hFFFF, 8'd0);
      queue_item(OP_LOAD, 12'd0, 12'd0, 16'h8001, 8'd255);
      queue_item(OP_LOAD, 12'd0, 12'd0, 16'h1234, 8'd17);
      queue_item(OP_LOAD, 12'd0, 12'd0, 16'h0000, 8'd1);
      queue_item(OP_PASS, 12'd100, 12'd100, 16'hAAAA, 8'd0);
      queue_item(OP_PASS, 12'd115, 12'd115, 16'h5555, 8'd0);
      queue_item(OP_PASS, 12'd101, 12'd101, 16'h0000, 8'd0);
      queue_item(OP_PASS, 12'd101, 12'd100, 16'h7777, 8'd0);
      queue_item(OP_PASS, 12'd116, 12'd100, 16'h1111, 8'd0);
      queue_item(OP_PASS, 12'd100, 12'd99, 16'h2222, 8'd0);
      queue_item(OP_PASS, 12'd0, 12'd0, 16'h0000, 8'd0);
      queue_item(OP_PASS, 12'd4095, 12'd4095, 16'hFFFF, 8'hFF);
      wait_drained();

      // box past the frame edge, empty clip, zero line length
      set_config(12'd4088, 12'd4088, 12'd10, 12'd10, 12'd5, 12'd5, 13'd0);
      queue_item(OP_LOAD, 12'd0, 12'd0, 16'hBEEF, 8'd119);
      queue_item(OP_PASS, 12'd4095, 12'd4095, 16'h0001, 8'd0);
      queue_item(OP_PASS, 12'd4088, 12'd4088, 16'h0000, 8'd0);
      wait_drained();

      // box at origin, largest line length wraps the offset
      set_config(12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 13'd8191);
      queue_item(OP_PASS, 12'd0, 12'd0, 16'h0001, 8'd0);
      queue_item(OP_PASS, 12'd4095, 12'd4095, 16'h0000, 8'd0);
      queue_item(OP_PASS, 12'd15, 12'd15, 16'h4444, 8'd0);
      wait_drained();

      // inclusive clip bounds
      set_config(12'd100, 12'd100, 12'd10, 12'd10, 12'd20, 12'd20, 13'd4096);
      queue_item(OP_PASS, 12'd10, 12'd20, 16'h0101, 8'd0);
      queue_item(OP_PASS, 12'd20, 12'd10, 16'h0202, 8'd0);
      queue_item(OP_PASS, 12'd9, 12'd15, 16'h0303, 8'd0);
      queue_item(OP_PASS, 12'd21, 12'd15, 16'h0404, 8'd0);
      queue_item(OP_PASS, 12'd15, 12'd9, 16'h0505, 8'd0);
      queue_item(OP_PASS, 12'd15, 12'd21, 16'h0606, 8'd0);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         cx = pick_coord();
         cy = pick_coord();
         if ($urandom_range(0, 1) == 0) begin
            cl = cx - COORD_BITS'($urandom_range(0, 4));
            cr = cx + COORD_BITS'($urandom_range(0, 20));
            ct = cy - COORD_BITS'($urandom_range(0, 4));
            cb = cy + COORD_BITS'($urandom_range(0, 20));
         end else begin
            cl = pick_coord();
            cr = pick_coord();
            ct = pick_coord();
            cb = pick_coord();
            if (cl > cr && $urandom_range(0, 3) != 0) begin
               t = cl; cl = cr; cr = t;
            end
            if (ct > cb && $urandom_range(0, 3) != 0) begin
               t = ct; ct = cb; cb = t;
            end
         end
         ll = LINE_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 4096));
         set_config(cx, cy, cl, ct, cr, cb, ll);
         idling = (ph < RANDOM_PHASES - 2) && (ph % 3 != 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            x  = COORD_BITS'($urandom);
            y  = COORD_BITS'($urandom);
            v  = PIXEL_BITS'($urandom);
            si = INDEX_BITS'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 4) == 0) v = '0;
               queue_item(OP_LOAD, x, y, v, si);
            end else begin
               if ($urandom_range(0, 3) != 0) begin
                  x = cx + COORD_BITS'($urandom_range(0, 19)) - 12'd2;
                  y = cy + COORD_BITS'($urandom_range(0, 19)) - 12'd2;
               end
               queue_item(OP_PASS, x, y, v, si);
            end
         end
         wait_drained();
      end

      idling = 1'b0;
      wait_drained();
      repeat (8) @(negedge clock);
      if (due_pixels.size() != 0)
         report_fault($sformatf("%0d words never arrived", due_pixels.size()));
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
